// ===== rtl/cfrl_pkg.sv =====
// Shared types and constants for the command filter / ramp limiter.
// Holds the configuration set, the queued command beat and the result beat.
// No dependencies.
package cfrl_pkg;

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_PCT   = 3'd0;
  localparam logic [2:0] REG_MAX_PCT   = 3'd1;
  localparam logic [2:0] REG_ALPHA     = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP = 3'd3;
  localparam logic [2:0] REG_ALERT_THR = 3'd4;

  localparam logic signed [7:0] MIN_PCT_RESET   = 8'sd0;
  localparam logic signed [7:0] MAX_PCT_RESET   = 8'sd100;
  localparam logic [15:0]       ALPHA_RESET     = 16'd32768;
  localparam logic [15:0]       RAMP_STEP_RESET = 16'd256;
  localparam logic [7:0]        ALERT_THR_RESET = 8'd90;

  // Q1.15 unity
  localparam logic [15:0] ALPHA_ONE = 16'd32768;

  typedef struct packed {
    logic signed [7:0] min_pct;
    logic signed [7:0] max_pct;
    logic [15:0]       alpha;
    logic [15:0]       ramp_step;
    logic [7:0]        alert_thr;
  } cfg_t;

  // command as classified by the front end
  typedef struct packed {
    logic               tick;
    logic signed [15:0] requested;
    logic signed [7:0]  target;
    logic               sat;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } cmd_q_t;

  typedef struct packed {
    logic signed [15:0] requested_echo;
    logic signed [7:0]  clamped_target;
    logic signed [7:0]  output_percent;
    logic               saturation_flag;
    logic               alert_flag;
  } result_t;

endpackage

// ===== rtl/cfrl_fifo.sv =====
// Small register-based first-in first-out queue.
// Generic width and depth; used between front and back and on the result side.
// No dependencies.
module cfrl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [CW-1:0]    count_next;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo occupancy above depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CW'(1)))
    else $error("fifo count did not follow a lone push");

endmodule

// ===== rtl/cfrl_front.sv =====
// Front end: accepts command beats, clamps the request and queues every beat.
// Depends on cfrl_pkg and cfrl_fifo.
module cfrl_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 command,
  input  logic signed [15:0]   requested_percent,
  input  cfrl_pkg::cfg_t       cfg,
  output cfrl_pkg::cmd_q_t     q_out,
  input  logic                 q_pop
);

  import cfrl_pkg::*;

  localparam int EW = $bits(cmd_entry_t);

  cmd_entry_t         entry_in;
  logic [EW-1:0]      rdata;
  logic               q_empty;
  logic [1:0]         q_count;
  logic signed [15:0] lo16, hi16;
  logic signed [7:0]  target;

  assign lo16 = 16'(cfg.min_pct);
  assign hi16 = 16'(cfg.max_pct);

  // with crossed bounds the lower bound wins only for requests below it
  always_comb begin
    priority if (requested_percent < lo16) begin
      target = cfg.min_pct;
    end else if (requested_percent > hi16) begin
      target = cfg.max_pct;
    end else begin
      target = requested_percent[7:0];
    end
  end

  always_comb begin
    entry_in.tick      = (command == CMD_TICK);
    entry_in.requested = requested_percent;
    entry_in.target    = target;
    entry_in.sat       = (requested_percent != 16'(target));
  end

  cfrl_fifo #(
    .WIDTH (EW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign q_out.valid = !q_empty && (q_count != 2'd0);
  assign q_out.entry = cmd_entry_t'(rdata);

endmodule

// ===== rtl/cfrl_back.sv =====
// Back end: steps the filter and ramp state on tick commands and queues results.
// Depends on cfrl_pkg and cfrl_fifo.
module cfrl_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cfrl_pkg::cfg_t      cfg,
  input  cfrl_pkg::cmd_q_t    q_in,
  output logic                q_pop,
  input  logic                res_pop,
  output logic                res_empty,
  output cfrl_pkg::result_t   res_out
);

  import cfrl_pkg::*;

  localparam int VW = FRAC_BITS + 8;                 // fixed-point state width
  localparam int DW = VW + 1;
  localparam int PW = VW + 18;                       // product width
  localparam int CW = ((VW + 1) > 17 ? (VW + 1) : 17) + 1;
  localparam int RW = $bits(result_t);
  localparam int OUT_DEPTH = 4;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  localparam logic signed [PW-1:0] PROD_HALF    = PW'(16384);
  localparam logic signed [PW-1:0] PROD_HALF_M1 = PW'(16383);
  localparam logic signed [DW-1:0] OUT_HALF     = DW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] OUT_HALF_M1  = OUT_HALF - DW'(1);

  // state
  logic signed [15:0]   requested_store;
  logic signed [7:0]    target_store;
  logic                 saturated;
  logic signed [VW-1:0] filtered, filtered_next;
  logic signed [VW-1:0] ramped, ramped_next;
  logic                 alert_active;
  logic                 s1_valid, s1_tick;

  cmd_entry_t           e;
  logic [15:0]          alpha_eff;
  logic signed [DW-1:0] tgt_fx, diff, adj, filt_sum;
  logic signed [PW-1:0] prod, prod_r, prod_sh;
  logic signed [CW-1:0] delta, step_c, ramp_c, lo_fx, hi_fx, ramp_cl;

  logic signed [DW-1:0] out_sum, out_sh;
  logic signed [7:0]    rnd;
  logic [8:0]           rnd_ext, mag;
  logic                 alert_calc, alert_out;
  result_t              res_in;
  logic [RW-1:0]        res_rdata;
  logic                 res_full;
  logic [OCW-1:0]       res_count;

  assign e = q_in.entry;

  // take a command only when the result queue has room for everything in flight
  assign q_pop = q_in.valid &&
                 ((OCW'(res_count) + OCW'(s1_valid)) < OCW'(OUT_DEPTH));

  // low-pass step
  always_comb begin
    alpha_eff     = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    tgt_fx        = DW'(target_store) <<< FRAC_BITS;
    diff          = tgt_fx - DW'(filtered);
    prod          = PW'(diff) * PW'($signed({1'b0, alpha_eff}));
    prod_r        = prod + (prod[PW-1] ? PROD_HALF_M1 : PROD_HALF);
    prod_sh       = prod_r >>> 15;
    adj           = DW'(prod_sh);
    filt_sum      = DW'(filtered) + adj;
    filtered_next = VW'(filt_sum);
  end

  // slew limit then clamp; with crossed bounds the lower one wins only below it
  always_comb begin
    delta  = CW'(filtered_next) - CW'(ramped);
    step_c = CW'($signed({1'b0, cfg.ramp_step}));
    lo_fx  = CW'(cfg.min_pct) <<< FRAC_BITS;
    hi_fx  = CW'(cfg.max_pct) <<< FRAC_BITS;
    priority if (delta > step_c) begin
      ramp_c = CW'(ramped) + step_c;
    end else if (delta < -step_c) begin
      ramp_c = CW'(ramped) - step_c;
    end else begin
      ramp_c = CW'(filtered_next);
    end
    priority if (ramp_c < lo_fx) begin
      ramp_cl = lo_fx;
    end else if (ramp_c > hi_fx) begin
      ramp_cl = hi_fx;
    end else begin
      ramp_cl = ramp_c;
    end
    ramped_next = VW'(ramp_cl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_store <= '0;
      target_store    <= '0;
      saturated       <= 1'b0;
      filtered        <= '0;
      ramped          <= '0;
      s1_valid        <= 1'b0;
      s1_tick         <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s1_tick  <= q_pop && e.tick;
      if (q_pop) begin
        if (e.tick) begin
          filtered <= filtered_next;
          ramped   <= ramped_next;
        end else begin
          requested_store <= e.requested;
          target_store    <= e.target;
          saturated       <= e.sat;
        end
      end
    end
  end

  // output rounding, half away from zero, and alert
  always_comb begin
    out_sum    = DW'(ramped) + (ramped[VW-1] ? OUT_HALF_M1 : OUT_HALF);
    out_sh     = out_sum >>> FRAC_BITS;
    rnd        = out_sh[7:0];
    rnd_ext    = {rnd[7], rnd};
    mag        = rnd[7] ? (~rnd_ext + 9'd1) : rnd_ext;
    alert_calc = (mag >= {1'b0, cfg.alert_thr});
    alert_out  = s1_tick ? alert_calc : alert_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_active <= 1'b0;
    end else if (s1_tick) begin
      alert_active <= alert_calc;
    end
  end

  always_comb begin
    res_in.requested_echo  = requested_store;
    res_in.clamped_target  = target_store;
    res_in.output_percent  = rnd;
    res_in.saturation_flag = saturated;
    res_in.alert_flag      = alert_out;
  end

  cfrl_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_rdata),
    .empty (res_empty),
    .count (res_count)
  );

  assign res_out = result_t'(res_rdata);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !res_full)
    else $error("result beat dropped on a full queue");

  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_valid)
    else $error("taken command did not reach the output stage");

endmodule

// ===== rtl/command_filter_ramp_limiter.sv =====
// Command filter and ramp limiter: top level with the configuration registers.
// Depends on cfrl_pkg, cfrl_front, cfrl_back.
//
// Conditions a percent command. A set-target beat (command 0) clamps the request
// into [min_percent, max_percent]; a tick beat (command 1) moves the low-pass
// filtered value toward the target, slews the output by at most ramp_step and
// rounds it to an integer percent. Every input beat gives exactly one result
// beat. Both sides are queues: a new beat is taken every clock while full is
// low, and one result can be popped every clock, so the sustained rate is one
// item per cycle as long as results are popped and the result queue has room.
// A taken beat updates the registered state (one multiply, the slew compare
// and the clamp); the rounding stage then reads it and queues the result.
// Registers are written through cfg_write/cfg_index/cfg_data and should change
// only while no beat is in flight.
module command_filter_ramp_limiter #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic signed [15:0] requested_percent,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] requested_echo,
  output logic signed [7:0]  clamped_target,
  output logic signed [7:0]  output_percent,
  output logic               saturation_flag,
  output logic               alert_flag,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  import cfrl_pkg::*;

  cfg_t    cfg;
  cmd_q_t  cmd_q;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pct   <= MIN_PCT_RESET;
      cfg.max_pct   <= MAX_PCT_RESET;
      cfg.alpha     <= ALPHA_RESET;
      cfg.ramp_step <= RAMP_STEP_RESET;
      cfg.alert_thr <= ALERT_THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_PCT:   cfg.min_pct   <= cfg_data[7:0];
        REG_MAX_PCT:   cfg.max_pct   <= cfg_data[7:0];
        REG_ALPHA:     cfg.alpha     <= cfg_data;
        REG_RAMP_STEP: cfg.ramp_step <= cfg_data;
        REG_ALERT_THR: cfg.alert_thr <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  cfrl_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .command           (command),
    .requested_percent (requested_percent),
    .cfg               (cfg),
    .q_out             (cmd_q),
    .q_pop             (q_pop)
  );

  cfrl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_in      (cmd_q),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res_out   (res)
  );

  assign requested_echo  = res.requested_echo;
  assign clamped_target  = res.clamped_target;
  assign output_percent  = res.output_percent;
  assign saturation_flag = res.saturation_flag;
  assign alert_flag      = res.alert_flag;

endmodule
